@@ hw/rtl/fwnp_pkg.sv @@
package fwnp_pkg;

   // Queue geometry.
   localparam int unsigned QUEUE_DEPTH = 16;
   localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Field widths of the stream channels.
   localparam int unsigned CMD_W       = 2;
   localparam int unsigned VALUE_W     = 32;
   localparam int unsigned ENTRY_W     = 5;
   localparam int unsigned REQ_DATA_W  = 32;
   localparam int unsigned RSP_DATA_W  = 40;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PURGE = 2'd2;

   typedef logic [PTR_W-1:0]   ptr_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [VALUE_W-1:0] value_type;

   // Ring slot that lies a given number of entries past a base slot.
   // The sum stays below twice the depth, so one compare and subtract wraps it.
   function automatic ptr_type ring_add(input ptr_type base, input cnt_type offset);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(offset);
      if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
         sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
      end
      return PTR_W'(sum);
   endfunction

endpackage

@@ hw/rtl/fifo_with_negative_purge_core.sv @@
// Push, unknown commands and a pop from an empty queue answer in the cycle after the
// transaction is accepted, and the next command can follow while the reply is taken; a
// successful pop passes through S_POP (registered store read) and then the result register,
// holding the input off in S_POP. A purge holds the input off until it answers, set by the
// single read and single write port of the entry store.
// Reset (synchronous, active high) empties the queue and clears head, tail and count; the
// entry store itself is not cleared.
module fifo_with_negative_purge_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // push_value[31:0]
   input  logic [fwnp_pkg::REQ_DATA_W-1:0]   req_tdata,
   // cmd[1:0]
   input  logic [fwnp_pkg::CMD_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // pop_value[31:0], entry_count[36:32], is_empty[37], zero[39:38]
   output logic [fwnp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // ok[0]
   output logic                              rsp_tuser
);
   import fwnp_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP,
      S_PURGE
   } state_type;

   state_type state_ff, state_in;
   ptr_type   head_ff, head_in;
   ptr_type   tail_ff, tail_in;
   cnt_type   count_ff, count_in;
   cnt_type   rd_idx_ff, rd_idx_in;
   cnt_type   kept_ff, kept_in;
   logic      pv_ff, pv_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_ok_ff, rsp_ok_in;
   value_type        rsp_value_ff, rsp_value_in;
   cnt_type          rsp_count_ff, rsp_count_in;

   // Entry store: one write port, one registered read port.
   value_type        mem [QUEUE_DEPTH];
   value_type        rd_data_ff;
   ptr_type          rd_addr;
   ptr_type          wr_addr;
   value_type        wr_data;
   logic             wr_en;

   logic             out_free;
   logic             accept;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;

   // Next-state logic for the command sequencer.
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      kept_in      = kept_ff;
      pv_in        = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_value_in = rsp_value_ff;
      rsp_count_in = rsp_count_ff;
      rd_addr      = head_ff;
      wr_addr      = tail_ff;
      wr_data      = req_tdata;
      wr_en        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  CMD_PUSH: begin
                     rsp_valid_in = 1'b1;
                     rsp_value_in = '0;
                     if (count_ff < CNT_W'(QUEUE_DEPTH)) begin
                        wr_en        = 1'b1;
                        tail_in      = ring_add(tail_ff, CNT_W'(1));
                        count_in     = count_ff + CNT_W'(1);
                        rsp_ok_in    = 1'b1;
                        rsp_count_in = count_ff + CNT_W'(1);
                     end else begin
                        rsp_ok_in    = 1'b0;
                        rsp_count_in = count_ff;
                     end
                  end
                  CMD_POP: begin
                     if (count_ff != '0) begin
                        state_in = S_POP;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_ok_in    = 1'b0;
                        rsp_value_in = '0;
                        rsp_count_in = count_ff;
                     end
                  end
                  CMD_PURGE: begin
                     state_in  = S_PURGE;
                     rd_idx_in = '0;
                     kept_in   = '0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_ok_in    = 1'b0;
                     rsp_value_in = '0;
                     rsp_count_in = count_ff;
                  end
               endcase
            end
         end

         // Store data for the head slot is now available.
         S_POP: begin
            state_in     = S_IDLE;
            head_in      = ring_add(head_ff, CNT_W'(1));
            count_in     = count_ff - CNT_W'(1);
            rsp_valid_in = 1'b1;
            rsp_ok_in    = 1'b1;
            rsp_value_in = rd_data_ff;
            rsp_count_in = count_ff - CNT_W'(1);
         end

         // Read one entry a cycle; in the following cycle compact the non-negative ones.
         S_PURGE: begin
            rd_addr = ring_add(head_ff, rd_idx_ff);
            wr_addr = ring_add(head_ff, kept_ff);
            wr_data = rd_data_ff;
            if (rd_idx_ff != count_ff) begin
               rd_idx_in = rd_idx_ff + CNT_W'(1);
               pv_in     = 1'b1;
            end
            if (pv_ff && !rd_data_ff[VALUE_W-1]) begin
               wr_en   = 1'b1;
               kept_in = kept_ff + CNT_W'(1);
            end
            if ((rd_idx_ff == count_ff) && !pv_ff) begin
               state_in     = S_IDLE;
               count_in     = kept_ff;
               tail_in      = ring_add(head_ff, kept_ff);
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
               rsp_value_in = '0;
               rsp_count_in = kept_ff;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         kept_ff      <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         kept_ff      <= kept_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ok_ff    <= rsp_ok_in;
      rsp_value_ff <= rsp_value_in;
      rsp_count_ff <= rsp_count_in;
   end

   // Entry store access.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Result transaction packing.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = {2'b00, (rsp_count_ff == '0), ENTRY_W'(rsp_count_ff), rsp_value_ff};

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("entry count exceeds queue depth");

   a_tail_consistent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (tail_ff == ring_add(head_ff, count_ff)))
      else $error("tail slot does not match head plus count");

   a_purge_write_behind: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PURGE && wr_en) |-> (kept_ff < rd_idx_ff))
      else $error("purge write overtakes the read position");

   a_pop_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP) |-> !rsp_valid_ff)
      else $error("pop result would overwrite a pending result");

   a_purge_returns: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PURGE && state_in == S_IDLE) |=> (rsp_tvalid && rsp_tuser))
      else $error("purge ended without a successful result");
`endif

endmodule

@@ bench/tb_fifo_with_negative_purge_core.sv @@
module tb_fifo_with_negative_purge_core;

   import fwnp_pkg::*;

   // Command code that the block must reject without touching its state.
   localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

   localparam int RANDOM_COMMANDS = 1600;
   localparam int DRAIN_CYCLES    = 2 * QUEUE_DEPTH + 8;
   localparam int CYCLE_LIMIT     = 500000;
   localparam int HOLD_START      = 500;
   localparam int HOLD_CYCLES     = 300;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [VALUE_W-1:0] value;
   } queue_command_type;

   typedef struct packed {
      logic               ok;
      logic [VALUE_W-1:0] pop_value;
      logic [ENTRY_W-1:0] entry_count;
      logic               is_empty;
   } queue_reply_type;

   // Patterns the response side cycles through when it is not holding off.
   typedef enum int {
      READY_ALWAYS,
      READY_HALF,
      READY_SPARSE,
      READY_EVERY_THIRD
   } ready_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [CMD_W-1:0]      req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   // Commands waiting to be offered and replies waiting to arrive.
   queue_command_type commands_pending[$];
   queue_reply_type   replies_due[$];

   // Values the queue should hold, oldest first.
   logic [VALUE_W-1:0] held_values[$];

   int mismatch_count    = 0;
   int commands_accepted = 0;
   int replies_checked   = 0;
   int cycle_count       = 0;

   // Tallies for the closing summary.
   int pushes_taken   = 0;
   int pushes_refused = 0;
   int pops_taken     = 0;
   int pops_refused   = 0;
   int purge_count    = 0;
   int purge_dropped  = 0;
   int unknown_count  = 0;

   fifo_with_negative_purge_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Applies one command to the predicted queue contents and returns its reply.
   function automatic queue_reply_type apply_command(input logic [CMD_W-1:0] cmd,
                                                     input logic [VALUE_W-1:0] value);
      queue_reply_type    reply;
      logic [VALUE_W-1:0] kept[$];
      reply = '0;
      case (cmd)
         CMD_PUSH: begin
            if (held_values.size() < QUEUE_DEPTH) begin
               held_values.push_back(value);
               reply.ok = 1'b1;
               pushes_taken++;
            end else begin
               pushes_refused++;
            end
         end
         CMD_POP: begin
            if (held_values.size() != 0) begin
               reply.pop_value = held_values.pop_front();
               reply.ok = 1'b1;
               pops_taken++;
            end else begin
               pops_refused++;
            end
         end
         CMD_PURGE: begin
            // Negative entries go, the rest keep their order.
            foreach (held_values[i]) begin
               if (!held_values[i][VALUE_W-1]) begin
                  kept.push_back(held_values[i]);
               end
            end
            purge_dropped += held_values.size() - kept.size();
            held_values = kept;
            reply.ok = 1'b1;
            purge_count++;
         end
         default: begin
            unknown_count++;
         end
      endcase
      reply.entry_count = ENTRY_W'(held_values.size());
      reply.is_empty    = (held_values.size() == 0);
      return reply;
   endfunction

   function automatic void check_field(input string field, input logic [VALUE_W-1:0] want,
                                       input logic [VALUE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", field, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic void add_command(input logic [CMD_W-1:0] cmd,
                                       input logic [VALUE_W-1:0] value);
      queue_command_type item;
      item.cmd   = cmd;
      item.value = value;
      commands_pending.push_back(item);
   endfunction

   // Sender: offers pending commands in bursts separated by random gaps.
   int                burst_left = 0;
   int                gap_left   = 0;
   queue_command_type offer;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            replies_due.push_back(apply_command(req_tuser, req_tdata));
            commands_accepted++;
         end
         // A command still waiting for acceptance is held as it is.
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (commands_pending.size() != 0) begin
               offer = commands_pending.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= offer.cmd;
               req_tdata  <= offer.value;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: switches between ready patterns and holds off once for a long stretch.
   ready_style_type ready_mode   = READY_ALWAYS;
   int              mode_cycles  = 0;
   int              rx_cycles    = 0;
   int              hold_left    = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         mode_cycles = 0;
         rx_cycles   = 0;
         hold_left   = 0;
      end else begin
         rx_cycles++;
         if (rx_cycles == HOLD_START) begin
            hold_left = HOLD_CYCLES;
         end
         if (mode_cycles == 0) begin
            ready_mode  = ready_style_type'($urandom_range(0, 3));
            mode_cycles = $urandom_range(20, 120);
         end else begin
            mode_cycles--;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (ready_mode)
               READY_ALWAYS: rsp_tready <= 1'b1;
               READY_HALF:   rsp_tready <= 1'($urandom_range(0, 1));
               READY_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
               default:      rsp_tready <= (mode_cycles % 3 == 0);
            endcase
         end
      end
   end

   // Monitor: compares every reply transaction with the oldest prediction.
   queue_reply_type want;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (replies_due.size() == 0) begin
            $error("reply with no command outstanding: tdata %0h, tuser %0b",
                   rsp_tdata, rsp_tuser);
            mismatch_count++;
         end else begin
            want = replies_due.pop_front();
            check_field("ok", VALUE_W'(want.ok), VALUE_W'(rsp_tuser));
            check_field("pop_value", want.pop_value, rsp_tdata[31:0]);
            check_field("entry_count", VALUE_W'(want.entry_count), VALUE_W'(rsp_tdata[36:32]));
            check_field("is_empty", VALUE_W'(want.is_empty), VALUE_W'(rsp_tdata[37]));
            check_field("tdata padding", '0, VALUE_W'(rsp_tdata[39:38]));
            replies_checked++;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d replies outstanding",
                  cycle_count, replies_due.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      int                 phase_left;
      int                 fill_bias;
      int                 roll;
      logic [CMD_W-1:0]   cmd_pick;
      logic [VALUE_W-1:0] value_pick;

      phase_left = 0;
      fill_bias  = 50;

      // Directed part: empty-queue cases, unknown command, fill to full, purge.
      add_command(CMD_POP, 32'h0000_0000);
      add_command(CMD_PURGE, 32'hFFFF_FFFF);
      add_command(CMD_UNKNOWN, 32'hFFFF_FFFF);
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         add_command(CMD_PUSH, (i % 4 == 0) ? 32'h8000_0000 :
                               (i % 4 == 1) ? 32'h7FFF_FFFF :
                               (i % 4 == 2) ? 32'hFFFF_FFFF : VALUE_W'(i));
      end
      add_command(CMD_PUSH, 32'h1234_5678);
      add_command(CMD_UNKNOWN, 32'h0000_0000);
      add_command(CMD_POP, 32'h0000_0000);
      add_command(CMD_PURGE, 32'h0000_0000);
      add_command(CMD_POP, 32'h5555_AAAA);

      // Random part: phases that lean toward filling or draining the queue.
      for (int n = 0; n < RANDOM_COMMANDS; n++) begin
         if (phase_left == 0) begin
            fill_bias  = $urandom_range(20, 85);
            phase_left = $urandom_range(30, 120);
         end
         phase_left--;
         roll = $urandom_range(0, 99);
         if (roll < 2) begin
            cmd_pick = CMD_UNKNOWN;
         end else if (roll < 9) begin
            cmd_pick = CMD_PURGE;
         end else if ($urandom_range(0, 99) < fill_bias) begin
            cmd_pick = CMD_PUSH;
         end else begin
            cmd_pick = CMD_POP;
         end
         case ($urandom_range(0, 15))
            0:       value_pick = 32'h8000_0000;
            1:       value_pick = 32'h7FFF_FFFF;
            2:       value_pick = 32'hFFFF_FFFF;
            3:       value_pick = 32'h0000_0000;
            default: value_pick = $urandom;
         endcase
         add_command(cmd_pick, value_pick);
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Wait until every command is accepted and answered, then let the block settle.
      do begin
         @(negedge clock);
      end while (commands_pending.size() != 0 || req_tvalid || replies_due.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d commands: %0d pushes (%0d refused when full), %0d pops (%0d on empty)",
               commands_accepted, pushes_taken, pushes_refused, pops_taken, pops_refused);
      $display("%0d purges dropping %0d negative entries, %0d unknown commands, %0d replies checked",
               purge_count, purge_dropped, unknown_count, replies_checked);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
